>>> hdl/cau_pkg.sv
package cau_pkg;

    // port width of every operand and result word
    localparam int PORT_W = 32;

    // command codes
    typedef enum logic [2:0] {
        CMD_ADD  = 3'd0,
        CMD_SUB  = 3'd1,
        CMD_MUL  = 3'd2,
        CMD_DIV  = 3'd3,
        CMD_CONJ = 3'd4
    } t_cmd;

    // status codes
    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_SAT  = 2'd1;
    localparam logic [1:0] ST_DIVZ = 2'd2;

endpackage

>>> hdl/cau_cell.sv
module cau_cell #(
    parameter int DW     = 32,
    parameter int SIDE_W = 8
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_en,
    input  logic                    i_valid,
    input  logic [1:0][2*DW-1:0]    i_rem,
    input  logic [1:0][DW:0]        i_low,
    input  logic [1:0][DW:0]        i_q,
    input  logic [2*DW-1:0]         i_den,
    input  logic [SIDE_W-1:0]       i_side,
    output logic                    o_valid,
    output logic [1:0][2*DW-1:0]    o_rem,
    output logic [1:0][DW:0]        o_low,
    output logic [1:0][DW:0]        o_q,
    output logic [2*DW-1:0]         o_den,
    output logic [SIDE_W-1:0]       o_side
);
    localparam int RW = 2 * DW;

    logic [1:0][RW:0]   w_t;
    logic [1:0]         w_ge;
    logic [1:0][RW:0]   w_diff;
    logic [1:0][RW-1:0] n_rem;
    logic [1:0][DW:0]   n_low;
    logic [1:0][DW:0]   n_q;

    // one restoring step per lane: bring in next numerator bit, try subtract
    always_comb begin
        for (int l = 0; l < 2; l++) begin
            w_t[l]    = {i_rem[l], i_low[l][DW]};
            w_ge[l]   = (w_t[l] >= {1'b0, i_den});
            w_diff[l] = w_t[l] - {1'b0, i_den};
            n_rem[l]  = w_ge[l] ? w_diff[l][RW-1:0] : w_t[l][RW-1:0];
            n_low[l]  = {i_low[l][DW-1:0], 1'b0};
            n_q[l]    = {i_q[l][DW-1:0], w_ge[l]};
        end
    end

    // cell valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else if (i_en) begin
            o_valid <= i_valid;
        end
    end

    // cell payload
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_rem  <= n_rem;
            o_low  <= n_low;
            o_q    <= n_q;
            o_den  <= i_den;
            o_side <= i_side;
        end
    end

endmodule

>>> hdl/complex_arith_unit.sv
// Fixed-point complex ALU: add, subtract, multiply, divide, conjugate of A.
// Input channel: i_in_valid with i_command and the four operand parts; a word
// is taken at a clock edge where i_in_valid is high and o_in_stall is low.
// Output channel: o_out_valid with o_res_re, o_res_im, o_status; a word is
// taken where o_out_valid is high and i_out_stall is low.
// Operands and results are signed, DATA_WIDTH bits with FRAC_BITS fraction
// bits, sign extended on the 32-bit ports. Overflow saturates (status 1);
// divide by zero gives zero and status 2.
// Every command takes the same path: operand register, products, sums and
// divider setup, then one quotient bit per divider cell in the row of
// DATA_WIDTH + 1 divider cells, and the output register. Throughput: one
// word per cycle while the receiver does not stall the output.
// When the receiver stalls with a result waiting, the whole pipeline holds
// and o_in_stall is raised; it falls as soon as the result is taken.
// Reset (synchronous, active low) empties the pipeline; no results remain.
module complex_arith_unit #(
    parameter int DATA_WIDTH = 32,
    parameter int FRAC_BITS  = 16
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  logic [2:0]                        i_command,
    input  logic signed [cau_pkg::PORT_W-1:0] i_a_re,
    input  logic signed [cau_pkg::PORT_W-1:0] i_a_im,
    input  logic signed [cau_pkg::PORT_W-1:0] i_b_re,
    input  logic signed [cau_pkg::PORT_W-1:0] i_b_im,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic signed [cau_pkg::PORT_W-1:0] o_res_re,
    output logic signed [cau_pkg::PORT_W-1:0] o_res_im,
    output logic [1:0]                        o_status
);
    import cau_pkg::*;

    localparam int DW     = DATA_WIDTH;
    localparam int PW     = 2 * DW;
    localparam int SW     = 2 * DW + 1;
    localparam int NSW    = 2 * DW + FRAC_BITS;
    localparam int QW     = DW + 1;
    localparam int SIDE_W = 6 + 2 * DW + 2;
    localparam int NCELL  = DW + 1;

    localparam logic signed [SW-1:0] MAXW = {{(SW-DW+1){1'b0}}, {(DW-1){1'b1}}};
    localparam logic signed [SW-1:0] MINW = {{(SW-DW+1){1'b1}}, {(DW-1){1'b0}}};
    localparam logic [QW-1:0]        HALF = {2'b01, {(DW-1){1'b0}}};

    // saturate a wide signed value; returns {flag, value}
    function automatic logic [DW:0] sat_w(input logic signed [SW-1:0] v);
        logic [DW:0] r;
        if (v > MAXW) begin
            r = {1'b1, MAXW[DW-1:0]};
        end else if (v < MINW) begin
            r = {1'b1, MINW[DW-1:0]};
        end else begin
            r = {1'b0, v[DW-1:0]};
        end
        return r;
    endfunction

    logic w_en;

    // stage 0: operand register
    logic                 r_v0;
    t_cmd                 r_cmd0;
    logic signed [DW-1:0] r_ar0, r_ai0, r_br0, r_bi0;

    // stage 1: products and linear results
    logic                 r_v1;
    t_cmd                 r_cmd1;
    logic signed [PW-1:0] r_p_rr, r_p_ii, r_p_ri, r_p_ir, r_p_bb, r_p_cc;
    logic signed [DW:0]   r_lin_re1, r_lin_im1;
    logic signed [DW:0]   n_lin_re, n_lin_im;

    // stage 2: sums of products
    logic                 r_v2;
    t_cmd                 r_cmd2;
    logic signed [DW:0]   r_lin_re2, r_lin_im2;
    logic signed [SW-1:0] r_mre, r_mim, r_dre, r_dim;
    logic [PW-1:0]        r_den;

    // stage 3: divider setup and non-divide results
    logic                 r_cv;
    logic [1:0][PW-1:0]   r_crem;
    logic [1:0][DW:0]     r_clow;
    logic [PW-1:0]        r_cden;
    logic [SIDE_W-1:0]    r_cside;

    logic signed [SW-1:0] w_dnum [2];
    logic [1:0]           w_neg;
    logic [1:0]           w_ovf;
    logic [1:0][PW-1:0]   n_crem;
    logic [1:0][DW:0]     n_clow;
    logic [SW-1:0]        w_mag;
    logic [NSW-1:0]       w_nsh;
    logic [NSW-1:0]       w_hi;
    logic [DW:0]          w_sre, w_sim;
    logic                 w_is_div, w_divz;
    logic [1:0]           w_st;
    logic [SIDE_W-1:0]    n_cside;

    // cell row wiring
    logic [NCELL:0]       w_v;
    logic [1:0][PW-1:0]   w_rem  [NCELL+1];
    logic [1:0][DW:0]     w_low  [NCELL+1];
    logic [1:0][DW:0]     w_q    [NCELL+1];
    logic [PW-1:0]        w_den  [NCELL+1];
    logic [SIDE_W-1:0]    w_side [NCELL+1];

    // output stage
    logic                 r_ov;
    logic signed [DW-1:0] r_ore, r_oim;
    logic [1:0]           r_ost;
    logic signed [DW-1:0] n_ore, n_oim;
    logic [1:0]           n_ost;
    logic [DW:0]          w_fre, w_fim;

    // pipeline moves unless a result waits on a stalled receiver
    assign w_en       = !r_ov || !i_out_stall;
    assign o_in_stall = !w_en;

    // valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_cv <= 1'b0;
            r_ov <= 1'b0;
        end else if (w_en) begin
            r_v0 <= i_in_valid;
            r_v1 <= r_v0;
            r_v2 <= r_v1;
            r_cv <= r_v2;
            r_ov <= w_v[NCELL];
        end
    end

    // linear results for add, subtract and conjugate
    always_comb begin
        case (r_cmd0)
            CMD_ADD: begin
                n_lin_re = (DW+1)'(r_ar0) + (DW+1)'(r_br0);
                n_lin_im = (DW+1)'(r_ai0) + (DW+1)'(r_bi0);
            end
            CMD_SUB: begin
                n_lin_re = (DW+1)'(r_ar0) - (DW+1)'(r_br0);
                n_lin_im = (DW+1)'(r_ai0) - (DW+1)'(r_bi0);
            end
            CMD_CONJ: begin
                n_lin_re = (DW+1)'(r_ar0);
                n_lin_im = -((DW+1)'(r_ai0));
            end
            default: begin
                n_lin_re = '0;
                n_lin_im = '0;
            end
        endcase
    end

    // stage 3 setup
    always_comb begin
        w_dnum[0] = r_dre;
        w_dnum[1] = r_dim;
        w_mag     = '0;
        w_nsh     = '0;
        w_hi      = '0;
        for (int l = 0; l < 2; l++) begin
            w_neg[l]  = w_dnum[l][SW-1];
            w_mag     = w_neg[l] ? SW'(-w_dnum[l]) : SW'(w_dnum[l]);
            w_nsh     = NSW'(w_mag[PW-1:0]) << FRAC_BITS;
            w_hi      = w_nsh >> (DW + 1);
            w_ovf[l]  = (w_hi >= NSW'(r_den));
            n_crem[l] = w_hi[PW-1:0];
            n_clow[l] = w_nsh[DW:0];
        end
        w_is_div = (r_cmd2 == CMD_DIV);
        w_divz   = (r_den == '0);
        if (r_cmd2 == CMD_MUL) begin
            w_sre = sat_w(r_mre >>> FRAC_BITS);
            w_sim = sat_w(r_mim >>> FRAC_BITS);
        end else begin
            w_sre = sat_w(SW'(r_lin_re2));
            w_sim = sat_w(SW'(r_lin_im2));
        end
        w_st    = (w_sre[DW] || w_sim[DW]) ? ST_SAT : ST_OK;
        n_cside = {w_is_div, w_divz, w_neg, w_ovf, w_sre[DW-1:0], w_sim[DW-1:0], w_st};
    end

    // arithmetic pipeline payload
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_cmd0    <= t_cmd'(i_command);
            r_ar0     <= i_a_re[DW-1:0];
            r_ai0     <= i_a_im[DW-1:0];
            r_br0     <= i_b_re[DW-1:0];
            r_bi0     <= i_b_im[DW-1:0];

            r_cmd1    <= r_cmd0;
            r_p_rr    <= r_ar0 * r_br0;
            r_p_ii    <= r_ai0 * r_bi0;
            r_p_ri    <= r_ar0 * r_bi0;
            r_p_ir    <= r_ai0 * r_br0;
            r_p_bb    <= r_br0 * r_br0;
            r_p_cc    <= r_bi0 * r_bi0;
            r_lin_re1 <= n_lin_re;
            r_lin_im1 <= n_lin_im;

            r_cmd2    <= r_cmd1;
            r_lin_re2 <= r_lin_re1;
            r_lin_im2 <= r_lin_im1;
            r_mre     <= SW'(r_p_rr) - SW'(r_p_ii);
            r_mim     <= SW'(r_p_ri) + SW'(r_p_ir);
            r_dre     <= SW'(r_p_rr) + SW'(r_p_ii);
            r_dim     <= SW'(r_p_ir) - SW'(r_p_ri);
            r_den     <= $unsigned(r_p_bb) + $unsigned(r_p_cc);

            r_crem    <= n_crem;
            r_clow    <= n_clow;
            r_cden    <= r_den;
            r_cside   <= n_cside;
        end
    end

    // divider row, one quotient bit per cell
    assign w_v[0]    = r_cv;
    assign w_rem[0]  = r_crem;
    assign w_low[0]  = r_clow;
    assign w_q[0]    = '0;
    assign w_den[0]  = r_cden;
    assign w_side[0] = r_cside;

    for (genvar k = 0; k < NCELL; k++) begin : g_cell
        cau_cell #(
            .DW     (DW),
            .SIDE_W (SIDE_W)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_valid (w_v[k]),
            .i_rem   (w_rem[k]),
            .i_low   (w_low[k]),
            .i_q     (w_q[k]),
            .i_den   (w_den[k]),
            .i_side  (w_side[k]),
            .o_valid (w_v[k+1]),
            .o_rem   (w_rem[k+1]),
            .o_low   (w_low[k+1]),
            .o_q     (w_q[k+1]),
            .o_den   (w_den[k+1]),
            .o_side  (w_side[k+1])
        );
    end

    // quotient sign, saturation and final select
    function automatic logic [DW:0] div_fin(input logic [QW-1:0] q, input logic neg,
                                            input logic ovf);
        logic [DW:0]   r;
        logic [QW-1:0] nq;
        nq = -q;
        if (neg) begin
            if (ovf || q > HALF) begin
                r = {1'b1, MINW[DW-1:0]};
            end else begin
                r = {1'b0, nq[DW-1:0]};
            end
        end else begin
            if (ovf || q > HALF - QW'(1)) begin
                r = {1'b1, MAXW[DW-1:0]};
            end else begin
                r = {1'b0, q[DW-1:0]};
            end
        end
        return r;
    endfunction

    // lane 0 sign and overflow sit below lane 1 in the side word
    always_comb begin
        w_fre = div_fin(w_q[NCELL][0], w_side[NCELL][SIDE_W-4], w_side[NCELL][SIDE_W-6]);
        w_fim = div_fin(w_q[NCELL][1], w_side[NCELL][SIDE_W-3], w_side[NCELL][SIDE_W-5]);
        if (!w_side[NCELL][SIDE_W-1]) begin
            n_ore = w_side[NCELL][2*DW+1:DW+2];
            n_oim = w_side[NCELL][DW+1:2];
            n_ost = w_side[NCELL][1:0];
        end else if (w_side[NCELL][SIDE_W-2]) begin
            n_ore = '0;
            n_oim = '0;
            n_ost = ST_DIVZ;
        end else begin
            n_ore = w_fre[DW-1:0];
            n_oim = w_fim[DW-1:0];
            n_ost = (w_fre[DW] || w_fim[DW]) ? ST_SAT : ST_OK;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_ore <= n_ore;
            r_oim <= n_oim;
            r_ost <= n_ost;
        end
    end

    assign o_out_valid = r_ov;
    assign o_res_re    = PORT_W'(r_ore);
    assign o_res_im    = PORT_W'(r_oim);
    assign o_status    = r_ost;

`ifndef NO_ASSERTIONS
    a_in_enters: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> r_v0)
        else $error("accepted word did not enter the pipeline");
    a_divz_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_status == ST_DIVZ |-> o_res_re == '0 && o_res_im == '0)
        else $error("divide by zero result not zero");
    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_status == ST_OK || o_status == ST_SAT || o_status == ST_DIVZ)
        else $error("undefined status code");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ov && i_out_stall |=> $stable(w_v))
        else $error("divider row moved while output stalled");
`endif

endmodule

>>> tb/sv/complex_arith_unit_test.sv
`timescale 1ns / 100ps

module complex_arith_unit_test;
    import cau_pkg::*;

    localparam int DW = 32;
    localparam int FB = 16;
    localparam int LATENCY = DW + 6;

    typedef struct packed {
        logic signed [31:0] re;
        logic signed [31:0] im;
        logic [1:0]         st;
    } t_res;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              i_in_valid = 1'b0;
    logic              o_in_stall;
    logic [2:0]        i_command = '0;
    logic signed [31:0] i_a_re = '0, i_a_im = '0, i_b_re = '0, i_b_im = '0;
    logic              o_out_valid;
    logic              i_out_stall = 1'b0;
    logic signed [31:0] o_res_re, o_res_im;
    logic [1:0]        o_status;

    t_res exp_results[$];
    int   err_count = 0;
    bit   idle_enable = 1'b1;

    complex_arith_unit dut (.*);

    always #4 i_clk = ~i_clk;

    // saturate a wide exact value to the DW signed range
    function automatic logic signed [31:0] sat_word(input logic signed [159:0] v,
                                                    inout bit flag);
        logic signed [159:0] maxv, minv;
        maxv = (160'sd1 <<< (DW - 1)) - 1;
        minv = -maxv - 1;
        if (v > maxv) begin
            flag = 1'b1;
            return maxv[31:0];
        end
        if (v < minv) begin
            flag = 1'b1;
            return minv[31:0];
        end
        return v[31:0];
    endfunction

    // divide toward zero after scaling by the fraction bits
    function automatic logic signed [159:0] div_trunc(input logic signed [159:0] num,
                                                      input logic signed [159:0] den);
        logic signed [159:0] mag;
        mag = (num < 0) ? -num : num;
        mag = (mag <<< FB) / den;
        return (num < 0) ? -mag : mag;
    endfunction

    function automatic t_res complex_result(input logic [2:0] cmd,
                                            input logic signed [31:0] ar, ai, br, bi);
        logic signed [159:0] wr, wi, xr, xi, yr, yi, den;
        bit   flag;
        t_res r;
        xr = ar; xi = ai; yr = br; yi = bi;
        wr = 0; wi = 0; flag = 1'b0; r.st = ST_OK;
        case (cmd)
            CMD_ADD: begin wr = xr + yr; wi = xi + yi; end
            CMD_SUB: begin wr = xr - yr; wi = xi - yi; end
            CMD_MUL: begin
                wr = (xr * yr - xi * yi) >>> FB;
                wi = (xr * yi + xi * yr) >>> FB;
            end
            CMD_DIV: begin
                den = yr * yr + yi * yi;
                if (den == 0) r.st = ST_DIVZ;
                else begin
                    wr = div_trunc(xr * yr + xi * yi, den);
                    wi = div_trunc(xi * yr - xr * yi, den);
                end
            end
            CMD_CONJ: begin wr = xr; wi = -xi; end
            default: ;
        endcase
        r.re = sat_word(wr, flag);
        r.im = sat_word(wi, flag);
        if (r.st == ST_OK && flag) r.st = ST_SAT;
        return r;
    endfunction

    task automatic report_mismatch(input string what);
        err_count++;
        $display("ERROR %0t: %s", $realtime, what);
    endtask

    // send one word, with optional random gap first; valid stays high between words
    task automatic send_word(input logic [2:0] cmd,
                             input logic signed [31:0] ar, ai, br, bi);
        if (idle_enable && $urandom_range(0, 5) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_command <= cmd;
        i_a_re <= ar; i_a_im <= ai; i_b_re <= br; i_b_im <= bi;
        exp_results.push_back(complex_result(cmd, ar, ai, br, bi));
        do @(posedge i_clk); while (o_in_stall);
        @(negedge i_clk);
    endtask

    // output stall bursts
    initial begin
        forever begin
            @(negedge i_clk);
            if (idle_enable && $urandom_range(0, 7) == 0) begin
                i_out_stall <= 1'b1;
                repeat ($urandom_range(1, 6)) @(negedge i_clk);
            end
            i_out_stall <= 1'b0;
        end
    end

    // result checker
    always @(posedge i_clk) begin
        t_res e;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (exp_results.size() == 0) report_mismatch("unexpected result word");
            else begin
                e = exp_results.pop_front();
                if (o_res_re !== e.re)
                    report_mismatch($sformatf("res_re %h exp %h", o_res_re, e.re));
                if (o_res_im !== e.im)
                    report_mismatch($sformatf("res_im %h exp %h", o_res_im, e.im));
                if (o_status !== e.st)
                    report_mismatch($sformatf("status %0d exp %0d", o_status, e.st));
            end
        end
    end

    function automatic logic signed [31:0] rand_operand();
        case ($urandom_range(0, 5))
            0: return 32'sh8000_0000;
            1: return 32'sh7fff_ffff;
            2: return $signed($urandom_range(0, 32'h3_ffff)) - 32'sh2_0000;
            3: return 32'sd0;
            default: return $urandom();
        endcase
    endfunction

    task automatic test_directed();
        logic signed [31:0] mn, mx;
        mn = 32'sh8000_0000;
        mx = 32'sh7fff_ffff;
        for (int c = 0; c < 8; c++) send_word(c[2:0], mx, mn, mx, mn);
        send_word(CMD_ADD, mx, mn, 32'sd1, -32'sd1);
        send_word(CMD_SUB, mn, mx, 32'sd1, -32'sd1);
        send_word(CMD_MUL, mn, mn, mn, mn);
        send_word(CMD_MUL, 32'sh1_0000, 32'sh2_0000, 32'sh3_0000, -32'sh1);
        send_word(CMD_DIV, 32'sh1_0000, 32'sh1_0000, 32'sd0, 32'sd0);
        send_word(CMD_DIV, mx, mx, 32'sd1, 32'sd0);
        send_word(CMD_DIV, -32'sh3_0000, 32'sh1_0000, 32'sh2_0000, -32'sh1_0000);
        send_word(CMD_DIV, 32'sd1, -32'sd1, mn, mn);
        send_word(CMD_CONJ, 32'sh1234_5678, mn, 32'sd0, 32'sd0);
        send_word(CMD_CONJ, mn, mx, 32'sd0, 32'sd0);
        send_word(CMD_ADD, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff);
    endtask

    task automatic test_random(input int n);
        logic [2:0] cmd;
        for (int k = 0; k < n; k++) begin
            cmd = ($urandom_range(0, 19) == 0) ? 3'($urandom_range(5, 7))
                                               : 3'($urandom_range(0, 4));
            send_word(cmd, rand_operand(), rand_operand(), rand_operand(),
                      rand_operand());
        end
    endtask

    task automatic test_back_to_back(input int n);
        idle_enable = 1'b0;
        for (int k = 0; k < n; k++)
            send_word(3'($urandom_range(0, 4)), $urandom(), $urandom(), $urandom(),
                      $urandom());
    endtask

    initial begin
        repeat (3) @(negedge i_clk);
        i_rst_n <= 1'b1;
        test_directed();
        test_random(1150);
        test_back_to_back(150);
        i_in_valid <= 1'b0;
        while (exp_results.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 4) @(posedge i_clk);
        if (err_count == 0) $display("Testbench completed without errors");
        else $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // run limit
    initial begin
        #2000000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end
endmodule

>>> files.f
hdl/cau_pkg.sv
hdl/cau_cell.sv
hdl/complex_arith_unit.sv
tb/sv/complex_arith_unit_test.sv
